// ----- design/dbpf_pkg.sv -----
// ----------------------------------------------------------------------------
// dbpf_pkg
// Shared types, constants and helpers of the depth binned peak finder.
// ----------------------------------------------------------------------------
package dbpf_pkg;

  localparam int SAMPLE_DEPTH = 1024;
  localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
  localparam int SCNT_W       = SAMPLE_AW + 1;
  localparam int MAX_BINS     = 64;
  localparam int BIN_AW       = $clog2(MAX_BINS);
  localparam int NBINS_W      = BIN_AW + 1;
  localparam int SUM_W        = 42;
  localparam int BCNT_W       = 11;
  localparam int DIV_W        = 44;
  localparam int DEN_W        = 16;
  localparam int PROD_W       = SUM_W + BCNT_W + 1;

  localparam logic [BCNT_W-1:0] COUNT_MAX = '1;
  localparam logic [15:0]       BIN_SIZE_RST = 16'd160;

  typedef struct packed {
    logic signed [SUM_W-1:0]  rd_sum;
    logic signed [SUM_W-1:0]  x_sum;
    logic signed [SUM_W-1:0]  y_sum;
    logic        [BCNT_W-1:0] cnt;
  } bin_entry_t;

  localparam int BIN_ENTRY_W = $bits(bin_entry_t);

  typedef struct packed {
    logic signed [SUM_W-1:0] val;
    logic                    ovf;
  } sat_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SPAN, S_SPAN_W, S_BIN_RD, S_BIN_DIV, S_BIN_W, S_BIN_UPD,
    S_SRCH_RD, S_SRCH_MUL, S_SRCH_CMP, S_PEAK, S_MEAN_GO, S_MEAN_W, S_OUT
  } state_t;

  typedef enum logic [1:0] {MEAN_RD, MEAN_X, MEAN_Y} mean_sel_t;

  function automatic logic signed [31:0] clamp32(input logic signed [DIV_W-1:0] v);
    logic signed [DIV_W-1:0] hi;
    logic signed [DIV_W-1:0] lo;
    hi = DIV_W'(32'sh7FFFFFFF);
    lo = -hi - DIV_W'(1);
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic sat_res_t sat_add(input logic signed [SUM_W-1:0] a,
                                       input logic signed [31:0] b);
    logic signed [SUM_W:0] s;
    sat_res_t r;
    s = {a[SUM_W-1], a} + {{(SUM_W-31){b[31]}}, b};
    r.ovf = s[SUM_W] != s[SUM_W-1];
    if (!r.ovf) r.val = s[SUM_W-1:0];
    else if (!s[SUM_W]) r.val = {1'b0, {(SUM_W-1){1'b1}}};
    else r.val = {1'b1, {(SUM_W-1){1'b0}}};
    return r;
  endfunction

endpackage

// ----- design/dbpf_in_if.sv -----
// ----------------------------------------------------------------------------
// dbpf_in_if
// Sample request channel: valid/ready handshake with the sample fields.
// ----------------------------------------------------------------------------
interface dbpf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] height;
  logic signed [31:0] reading;
  logic               last_sample;

  modport source (output valid, pos_x, pos_y, height, reading, last_sample,
                  input ready);
  modport sink (input valid, pos_x, pos_y, height, reading, last_sample,
                output ready);
endinterface

// ----- design/dbpf_out_if.sv -----
// ----------------------------------------------------------------------------
// dbpf_out_if
// Result request channel: valid/ready handshake with the peak fields.
// ----------------------------------------------------------------------------
interface dbpf_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] peak_height;
  logic signed [31:0] peak_strength;
  logic signed [31:0] mean_x;
  logic signed [31:0] mean_y;
  logic               overflow;

  modport source (output valid, found, peak_height, peak_strength, mean_x, mean_y,
                  overflow, input ready);
  modport sink (input valid, found, peak_height, peak_strength, mean_x, mean_y,
                overflow, output ready);
endinterface

// ----- design/dbpf_sample_mem.sv -----
// ----------------------------------------------------------------------------
// dbpf_sample_mem
// Sample buffer: x, y, height and reading packed in one synchronous memory.
// ----------------------------------------------------------------------------
module dbpf_sample_mem (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [dbpf_pkg::SAMPLE_AW-1:0]  wr_addr,
  input  logic [127:0]                    wr_data,
  input  logic                            rd_en,
  input  logic [dbpf_pkg::SAMPLE_AW-1:0]  rd_addr,
  output logic [127:0]                    rd_data
);

  logic [127:0] mem [dbpf_pkg::SAMPLE_DEPTH];
  logic [127:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/dbpf_bin_mem.sv -----
// ----------------------------------------------------------------------------
// dbpf_bin_mem
// Per-bin sums and counts; valid bits make a cleared entry read as zero.
// ----------------------------------------------------------------------------
module dbpf_bin_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         wr_en,
  input  logic [dbpf_pkg::BIN_AW-1:0]  wr_addr,
  input  dbpf_pkg::bin_entry_t         wr_data,
  input  logic                         rd_en,
  input  logic [dbpf_pkg::BIN_AW-1:0]  rd_addr,
  output dbpf_pkg::bin_entry_t         rd_data
);

  dbpf_pkg::bin_entry_t             mem [dbpf_pkg::MAX_BINS];
  logic [dbpf_pkg::MAX_BINS-1:0]    vld_r;
  dbpf_pkg::bin_entry_t             rd_data_r;
  logic                             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ----- design/dbpf_divider.sv -----
// ----------------------------------------------------------------------------
// dbpf_divider
// Shared signed-by-unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module dbpf_divider (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [dbpf_pkg::DIV_W-1:0]    dividend,
  input  logic        [dbpf_pkg::DEN_W-1:0]    divisor,
  output logic                                 done,
  output logic signed [dbpf_pkg::DIV_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(dbpf_pkg::DIV_W + 1);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [dbpf_pkg::DEN_W-1:0]    rem_r;
  logic [dbpf_pkg::DEN_W-1:0]    den_r;
  logic [dbpf_pkg::DIV_W-1:0]    quo_r;
  logic                          neg_r;
  logic [dbpf_pkg::DEN_W:0]      trial;
  logic                          take;

  assign trial = {rem_r, quo_r[dbpf_pkg::DIV_W-1]};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(dbpf_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[dbpf_pkg::DIV_W-1];
      quo_r <= dividend[dbpf_pkg::DIV_W-1] ? -dividend : dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? dbpf_pkg::DEN_W'(trial - {1'b0, den_r})
                    : trial[dbpf_pkg::DEN_W-1:0];
      quo_r <= {quo_r[dbpf_pkg::DIV_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

// ----- design/depth_binned_peak_finder_unit.sv -----
// ----------------------------------------------------------------------------
// depth_binned_peak_finder_unit
// Buffers a batch of samples, bins them by height and reports the peak bin.
// ----------------------------------------------------------------------------
// Samples arrive on in_ch (valid/ready), one request per cycle while loading;
// each of the first 1024 is written to the sample buffer, with the least and
// greatest height tracked; later ones are dropped and flag overflow. A request
// with last_sample set ends the batch and starts the evaluation, during which
// in_ch.ready is low. Evaluation: one division gives the bin count, then each
// stored sample goes through a buffer read, a bin index division and a bin
// read-modify-write, the search reads and compares each bin in turn, and three
// divisions give the means (only the bin count division when all heights are
// equal, since no bin is then formed).
// One result leaves on out_ch per batch; it sits in an output register, so
// the next batch loads while it waits. If the receiver stalls with a result
// still held, the next result waits at the end of its evaluation.
// cfg_we/cfg_wdata write bin_size (0 acts as 1); write only while idle.
// Reset (rst_n low, synchronous) sets bin_size to 160 and empties the batch.
// ----------------------------------------------------------------------------
module depth_binned_peak_finder_unit (
  input  logic             clk,
  input  logic             rst_n,
  dbpf_in_if.sink          in_ch,
  dbpf_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  localparam int DW = dbpf_pkg::DIV_W;

  dbpf_pkg::state_t            state_r, state_nxt;
  logic [15:0]                 bin_size_r;
  logic [15:0]                 size_w;
  logic signed [31:0]          least_r, greatest_r;
  logic [dbpf_pkg::SCNT_W-1:0] cnt_r;
  logic                        ovf_r;
  logic [dbpf_pkg::SCNT_W-1:0] idx_r;
  logic [dbpf_pkg::NBINS_W-1:0] nbins_r;
  logic [dbpf_pkg::BIN_AW-1:0] b_r;
  logic [dbpf_pkg::BIN_AW-1:0] b_w;
  logic                        best_vld_r;
  logic [dbpf_pkg::BIN_AW-1:0] best_idx_r;
  dbpf_pkg::bin_entry_t        best_r, cur_r;
  logic signed [dbpf_pkg::PROD_W-1:0] prod_a_r, prod_b_r;
  dbpf_pkg::mean_sel_t         sel_r;
  logic                        res_found_r;
  logic signed [31:0]          res_ph_r, res_pk_r, res_mx_r, res_my_r;

  logic                        out_vld_r;
  logic                        out_found_r, out_ovf_r;
  logic signed [31:0]          out_ph_r, out_pk_r, out_mx_r, out_my_r;

  logic                        in_acc;
  logic [127:0]                smp_rd;
  logic                        smp_we;
  dbpf_pkg::bin_entry_t        bin_rd, bin_wr;
  logic                        bin_rd_en;
  logic [dbpf_pkg::BIN_AW-1:0] bin_rd_addr;
  logic                        div_start, div_done;
  logic signed [DW-1:0]        div_a, div_q;
  logic [15:0]                 div_d;
  logic signed [32:0]          span_w;
  dbpf_pkg::sat_res_t          sr_rd, sr_x, sr_y;
  logic signed [DW-1:0]        ph_w;
  logic [15:0]                 best_cnt_w;

  assign size_w = (bin_size_r == 16'd0) ? 16'd1 : bin_size_r;
  assign in_ch.ready = (state_r == dbpf_pkg::S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign smp_we = in_acc && (cnt_r < dbpf_pkg::SCNT_W'(dbpf_pkg::SAMPLE_DEPTH));

  dbpf_sample_mem u_smp (
    .clk     (clk),
    .wr_en   (smp_we),
    .wr_addr (cnt_r[dbpf_pkg::SAMPLE_AW-1:0]),
    .wr_data ({in_ch.pos_x, in_ch.pos_y, in_ch.height, in_ch.reading}),
    .rd_en   (state_r == dbpf_pkg::S_BIN_RD),
    .rd_addr (idx_r[dbpf_pkg::SAMPLE_AW-1:0]),
    .rd_data (smp_rd)
  );

  // bin index from the divider, top heights fold into the last bin
  assign b_w = (div_q >= DW'(nbins_r)) ? dbpf_pkg::BIN_AW'(nbins_r - 1'b1)
                                       : div_q[dbpf_pkg::BIN_AW-1:0];

  assign bin_rd_en = (state_r == dbpf_pkg::S_BIN_W && div_done) ||
                     (state_r == dbpf_pkg::S_SRCH_RD);
  assign bin_rd_addr = (state_r == dbpf_pkg::S_BIN_W) ? b_w
                                                      : idx_r[dbpf_pkg::BIN_AW-1:0];

  assign sr_rd = dbpf_pkg::sat_add(bin_rd.rd_sum, smp_rd[31:0]);
  assign sr_y  = dbpf_pkg::sat_add(bin_rd.y_sum, smp_rd[95:64]);
  assign sr_x  = dbpf_pkg::sat_add(bin_rd.x_sum, smp_rd[127:96]);

  always_comb begin
    bin_wr.rd_sum = sr_rd.val;
    bin_wr.x_sum  = sr_x.val;
    bin_wr.y_sum  = sr_y.val;
    bin_wr.cnt    = (bin_rd.cnt == dbpf_pkg::COUNT_MAX) ? bin_rd.cnt
                                                        : bin_rd.cnt + 1'b1;
  end

  dbpf_bin_mem u_bin (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (state_r == dbpf_pkg::S_SPAN),
    .wr_en   (state_r == dbpf_pkg::S_BIN_UPD),
    .wr_addr (b_r),
    .wr_data (bin_wr),
    .rd_en   (bin_rd_en),
    .rd_addr (bin_rd_addr),
    .rd_data (bin_rd)
  );

  assign span_w = (cnt_r == '0) ? 33'sd0
                : ({greatest_r[31], greatest_r} - {least_r[31], least_r});
  assign best_cnt_w = (best_r.cnt == '0) ? 16'd1 : 16'(best_r.cnt);

  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_d     = size_w;
    case (state_r)
      dbpf_pkg::S_SPAN: begin
        div_start = 1'b1;
        div_a = DW'(span_w) + DW'(size_w) - DW'(1);
      end
      dbpf_pkg::S_BIN_DIV: begin
        div_start = 1'b1;
        div_a = DW'($signed(smp_rd[63:32])) - DW'(least_r);
      end
      dbpf_pkg::S_MEAN_GO: begin
        div_start = 1'b1;
        div_d = best_cnt_w;
        case (sel_r)
          dbpf_pkg::MEAN_X: div_a = DW'(best_r.x_sum);
          dbpf_pkg::MEAN_Y: div_a = DW'(best_r.y_sum);
          default:          div_a = DW'(best_r.rd_sum);
        endcase
      end
      default: ;
    endcase
  end

  dbpf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  assign ph_w = DW'(least_r) + DW'(best_idx_r) * DW'(size_w) + DW'(size_w >> 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dbpf_pkg::S_IDLE:    if (in_acc && in_ch.last_sample) state_nxt = dbpf_pkg::S_SPAN;
      dbpf_pkg::S_SPAN:    state_nxt = dbpf_pkg::S_SPAN_W;
      dbpf_pkg::S_SPAN_W: begin
        if (div_done) begin
          state_nxt = (div_q == '0) ? dbpf_pkg::S_OUT : dbpf_pkg::S_BIN_RD;
        end
      end
      dbpf_pkg::S_BIN_RD:  state_nxt = (idx_r == cnt_r) ? dbpf_pkg::S_SRCH_RD
                                                        : dbpf_pkg::S_BIN_DIV;
      dbpf_pkg::S_BIN_DIV: state_nxt = dbpf_pkg::S_BIN_W;
      dbpf_pkg::S_BIN_W:   if (div_done) state_nxt = dbpf_pkg::S_BIN_UPD;
      dbpf_pkg::S_BIN_UPD: state_nxt = dbpf_pkg::S_BIN_RD;
      dbpf_pkg::S_SRCH_RD: state_nxt = (idx_r == dbpf_pkg::SCNT_W'(nbins_r))
                                       ? dbpf_pkg::S_PEAK : dbpf_pkg::S_SRCH_MUL;
      dbpf_pkg::S_SRCH_MUL: state_nxt = dbpf_pkg::S_SRCH_CMP;
      dbpf_pkg::S_SRCH_CMP: state_nxt = dbpf_pkg::S_SRCH_RD;
      dbpf_pkg::S_PEAK:    state_nxt = dbpf_pkg::S_MEAN_GO;
      dbpf_pkg::S_MEAN_GO: state_nxt = dbpf_pkg::S_MEAN_W;
      dbpf_pkg::S_MEAN_W: begin
        if (div_done) begin
          state_nxt = (sel_r == dbpf_pkg::MEAN_Y) ? dbpf_pkg::S_OUT
                                                  : dbpf_pkg::S_MEAN_GO;
        end
      end
      dbpf_pkg::S_OUT:     if (!out_vld_r) state_nxt = dbpf_pkg::S_IDLE;
      default:             state_nxt = dbpf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dbpf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // batch control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_size_r <= dbpf_pkg::BIN_SIZE_RST;
      least_r    <= 32'sh7FFFFFFF;
      greatest_r <= 32'sh80000000;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      best_vld_r <= 1'b0;
      idx_r      <= '0;
      sel_r      <= dbpf_pkg::MEAN_RD;
    end else begin
      if (cfg_we) begin
        bin_size_r <= cfg_wdata;
      end
      case (state_r)
        dbpf_pkg::S_IDLE: begin
          if (in_acc) begin
            if (smp_we) begin
              cnt_r <= cnt_r + 1'b1;
              if (in_ch.height < least_r) least_r <= in_ch.height;
              if (in_ch.height > greatest_r) greatest_r <= in_ch.height;
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        dbpf_pkg::S_SPAN: begin
          best_vld_r <= 1'b0;
          idx_r      <= '0;
        end
        dbpf_pkg::S_SPAN_W: begin
          if (div_done && div_q > DW'(dbpf_pkg::MAX_BINS)) ovf_r <= 1'b1;
        end
        dbpf_pkg::S_BIN_RD: begin
          if (idx_r == cnt_r) idx_r <= '0;
        end
        dbpf_pkg::S_BIN_UPD: begin
          idx_r <= idx_r + 1'b1;
          if (sr_rd.ovf || sr_x.ovf || sr_y.ovf || bin_rd.cnt == dbpf_pkg::COUNT_MAX) begin
            ovf_r <= 1'b1;
          end
        end
        dbpf_pkg::S_SRCH_CMP: begin
          idx_r <= idx_r + 1'b1;
          if (cur_r.cnt != '0 && (!best_vld_r || prod_a_r > prod_b_r)) best_vld_r <= 1'b1;
        end
        dbpf_pkg::S_PEAK:   sel_r <= dbpf_pkg::MEAN_RD;
        dbpf_pkg::S_MEAN_W: begin
          if (div_done) begin
            case (sel_r)
              dbpf_pkg::MEAN_RD: sel_r <= dbpf_pkg::MEAN_X;
              dbpf_pkg::MEAN_X:  sel_r <= dbpf_pkg::MEAN_Y;
              default:           sel_r <= dbpf_pkg::MEAN_RD;
            endcase
          end
        end
        dbpf_pkg::S_OUT: begin
          if (!out_vld_r) begin
            least_r    <= 32'sh7FFFFFFF;
            greatest_r <= 32'sh80000000;
            cnt_r      <= '0;
            ovf_r      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      dbpf_pkg::S_SPAN_W: begin
        if (div_done) begin
          nbins_r     <= (div_q > DW'(dbpf_pkg::MAX_BINS))
                         ? dbpf_pkg::NBINS_W'(dbpf_pkg::MAX_BINS)
                         : div_q[dbpf_pkg::NBINS_W-1:0];
          res_found_r <= div_q != '0;
          res_ph_r    <= '0;
          res_pk_r    <= '0;
          res_mx_r    <= '0;
          res_my_r    <= '0;
        end
      end
      dbpf_pkg::S_BIN_W: if (div_done) b_r <= b_w;
      dbpf_pkg::S_SRCH_MUL: begin
        cur_r    <= bin_rd;
        // compare means by cross multiplication
        prod_a_r <= bin_rd.rd_sum * $signed({1'b0, best_r.cnt});
        prod_b_r <= best_r.rd_sum * $signed({1'b0, bin_rd.cnt});
      end
      dbpf_pkg::S_SRCH_CMP: begin
        if (cur_r.cnt != '0 && (!best_vld_r || prod_a_r > prod_b_r)) begin
          best_r     <= cur_r;
          best_idx_r <= idx_r[dbpf_pkg::BIN_AW-1:0];
        end
      end
      dbpf_pkg::S_PEAK: res_ph_r <= dbpf_pkg::clamp32(ph_w);
      dbpf_pkg::S_MEAN_W: begin
        if (div_done) begin
          case (sel_r)
            dbpf_pkg::MEAN_X: res_mx_r <= dbpf_pkg::clamp32(div_q);
            dbpf_pkg::MEAN_Y: res_my_r <= dbpf_pkg::clamp32(div_q);
            default:          res_pk_r <= dbpf_pkg::clamp32(div_q);
          endcase
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == dbpf_pkg::S_OUT && !out_vld_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == dbpf_pkg::S_OUT && !out_vld_r) begin
      out_found_r <= res_found_r;
      out_ph_r    <= res_ph_r;
      out_pk_r    <= res_pk_r;
      out_mx_r    <= res_mx_r;
      out_my_r    <= res_my_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.peak_height   = out_ph_r;
  assign out_ch.peak_strength = out_pk_r;
  assign out_ch.mean_x        = out_mx_r;
  assign out_ch.mean_y        = out_my_r;
  assign out_ch.overflow      = out_ovf_r;

endmodule

// ----- sim/dbpf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpf_checker
// Watches the sample and result channels and the bin_size writes, keeps its
// own copy of the batch, works out the peak bin on every last sample and
// compares each result against the oldest one pending.
// ----------------------------------------------------------------------------
module dbpf_checker (
  input  logic        clk,
  input  logic        rst_n,
  dbpf_in_if          in_mon,
  dbpf_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending_results
);

  typedef struct {
    logic               found;
    logic signed [31:0] peak_height;
    logic signed [31:0] peak_strength;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic               overflow;
  } peak_t;

  localparam longint SUM_HI = 64'sh1FFFFFFFFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  logic signed [31:0] hgt_mem [dbpf_pkg::SAMPLE_DEPTH];
  logic signed [31:0] x_mem [dbpf_pkg::SAMPLE_DEPTH];
  logic signed [31:0] y_mem [dbpf_pkg::SAMPLE_DEPTH];
  logic signed [31:0] rd_mem [dbpf_pkg::SAMPLE_DEPTH];
  logic signed [31:0] lo_hgt, hi_hgt;
  int                 n_stored;
  logic               dropped;
  logic [15:0]        bin_span;
  peak_t              peak_q [$];

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint acc_sat(input longint a, input longint b, inout logic ovf);
    longint s;
    s = a + b;
    if (s > SUM_HI) begin
      ovf = 1'b1;
      return SUM_HI;
    end
    if (s < SUM_LO) begin
      ovf = 1'b1;
      return SUM_LO;
    end
    return s;
  endfunction

  function automatic peak_t find_peak();
    longint rd_sum [dbpf_pkg::MAX_BINS];
    longint x_sum [dbpf_pkg::MAX_BINS];
    longint y_sum [dbpf_pkg::MAX_BINS];
    longint cnt [dbpf_pkg::MAX_BINS];
    longint size, span, nbins, b, best, c, ph;
    logic   ovf;
    peak_t  r;
    ovf = dropped;
    r = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0};
    for (int i = 0; i < dbpf_pkg::MAX_BINS; i++) begin
      rd_sum[i] = 0; x_sum[i] = 0; y_sum[i] = 0; cnt[i] = 0;
    end
    size = (bin_span == 0) ? 1 : longint'(bin_span);
    span = (n_stored == 0) ? 0 : longint'(hi_hgt) - longint'(lo_hgt);
    if (span < 0) span = 0;
    nbins = (span + size - 1) / size;
    if (nbins > dbpf_pkg::MAX_BINS) begin
      nbins = dbpf_pkg::MAX_BINS;
      ovf = 1'b1;
    end
    if (nbins > 0) begin
      for (int i = 0; i < n_stored; i++) begin
        b = (longint'(hgt_mem[i]) - longint'(lo_hgt)) / size;
        if (b < 0) b = 0;
        if (b >= nbins) b = nbins - 1;
        rd_sum[b] = acc_sat(rd_sum[b], longint'(rd_mem[i]), ovf);
        x_sum[b] = acc_sat(x_sum[b], longint'(x_mem[i]), ovf);
        y_sum[b] = acc_sat(y_sum[b], longint'(y_mem[i]), ovf);
        if (cnt[b] < 2047) cnt[b]++;
        else ovf = 1'b1;
      end
      best = -1;
      for (int i = 0; i < nbins; i++) begin
        if (cnt[i] != 0) begin
          // compare means by cross multiplication
          if (best < 0 || rd_sum[i] * cnt[best] > rd_sum[best] * cnt[i]) best = i;
        end
      end
      if (best < 0) best = 0;
      c = (cnt[best] != 0) ? cnt[best] : 1;
      ph = longint'(lo_hgt) + best * size + size / 2;
      r.found = 1'b1;
      r.peak_height = sat32(ph);
      r.peak_strength = sat32(rd_sum[best] / c);
      r.mean_x = sat32(x_sum[best] / c);
      r.mean_y = sat32(y_sum[best] / c);
    end
    r.overflow = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    peak_t got, want;
    if (!rst_n) begin
      bin_span <= dbpf_pkg::BIN_SIZE_RST;
      n_stored = 0;
      lo_hgt = 32'sh7FFFFFFF;
      hi_hgt = 32'sh80000000;
      dropped = 1'b0;
      peak_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) bin_span <= cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        if (n_stored < dbpf_pkg::SAMPLE_DEPTH) begin
          x_mem[n_stored] = in_mon.pos_x;
          y_mem[n_stored] = in_mon.pos_y;
          hgt_mem[n_stored] = in_mon.height;
          rd_mem[n_stored] = in_mon.reading;
          n_stored++;
          if (in_mon.height < lo_hgt) lo_hgt = in_mon.height;
          if (in_mon.height > hi_hgt) hi_hgt = in_mon.height;
        end else begin
          dropped = 1'b1;
        end
        if (in_mon.last_sample) begin
          peak_q = {peak_q, find_peak()};
          n_stored = 0;
          lo_hgt = 32'sh7FFFFFFF;
          hi_hgt = 32'sh80000000;
          dropped = 1'b0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.found, out_mon.peak_height, out_mon.peak_strength,
                out_mon.mean_x, out_mon.mean_y, out_mon.overflow};
        if (peak_q.size() == 0) begin
          $error("result with no request pending");
          fail_count <= fail_count + 1;
        end else begin
          want = peak_q.pop_front();
          if (got.found != want.found || got.peak_height != want.peak_height ||
              got.peak_strength != want.peak_strength || got.mean_x != want.mean_x ||
              got.mean_y != want.mean_y || got.overflow != want.overflow)
            fail_count <= fail_count + 1;
          if (got.found != want.found)
            $error("found: expected %0d got %0d", want.found, got.found);
          if (got.peak_height != want.peak_height)
            $error("peak_height: expected %0d got %0d", want.peak_height, got.peak_height);
          if (got.peak_strength != want.peak_strength)
            $error("peak_strength: expected %0d got %0d", want.peak_strength,
                   got.peak_strength);
          if (got.mean_x != want.mean_x)
            $error("mean_x: expected %0d got %0d", want.mean_x, got.mean_x);
          if (got.mean_y != want.mean_y)
            $error("mean_y: expected %0d got %0d", want.mean_y, got.mean_y);
          if (got.overflow != want.overflow)
            $error("overflow: expected %0d got %0d", want.overflow, got.overflow);
        end
      end
    end
    pending_results <= peak_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sample batches into the peak finder under several bin sizes, with
// random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending_results;
  int          cycle_cnt;
  int          n_sent;
  logic        gaps_on;
  int          hold_req;
  int          hold_seen;
  int          hold_left;
  logic [15:0] cur_bin;

  dbpf_in_if  in_ch ();
  dbpf_out_if out_ch ();

  depth_binned_peak_finder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  dbpf_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 6000;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !gaps_on || ($urandom_range(99) >= 36);
    end
  end

  task automatic send_sample(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] h, input logic signed [31:0] r,
                             input logic last);
    while (gaps_on && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    in_ch.height <= h;
    in_ch.reading <= r;
    in_ch.last_sample <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_bin(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cur_bin = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly small batches with heights over a few dozen bins
  task automatic random_batch(input int max_n);
    int          n;
    int          span;
    logic signed [31:0] base;
    logic        wild;
    n = $urandom_range(1, max_n);
    wild = ($urandom_range(9) == 0);
    base = $urandom;
    span = ((cur_bin == 0) ? 1 : cur_bin) * $urandom_range(1, 80);
    for (int i = 0; i < n; i++) begin
      send_sample($urandom, $urandom,
                  wild ? $urandom : base + $urandom_range(0, span),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 65535) - 32768,
                  i == n - 1);
    end
  endtask

  task automatic random_phase(input int items);
    int start;
    start = n_sent;
    while (n_sent - start < items) random_batch(12);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cycle_cnt = 0;
    n_sent = 0;
    gaps_on = 1'b1;
    hold_req = 0;
    cur_bin = dbpf_pkg::BIN_SIZE_RST;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.height = '0;
    in_ch.reading = '0;
    in_ch.last_sample = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single sample: nothing to bin
    send_sample(32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh7FFFFFFF, 1'b1);
    // equal heights
    send_sample(16, 32, 500, 100, 1'b0);
    send_sample(-16, 48, 500, 200, 1'b0);
    send_sample(0, 0, 500, 300, 1'b1);
    // extreme heights: bin count saturates, top goes to last bin
    send_sample(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 1'b0);
    send_sample(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    send_sample(-1, -1, 0, -1, 1'b1);
    // top height exactly on a bin edge
    send_sample(1, 2, 0, 10, 1'b0);
    send_sample(3, 4, 160, 20, 1'b0);
    send_sample(5, 6, 320, 30, 1'b1);
    // tie between two bins, lower one wins
    send_sample(100, 200, 0, 500, 1'b0);
    send_sample(300, 400, 200, 500, 1'b1);
    // empty bins between far apart samples
    send_sample(-7, 9, 0, -50, 1'b0);
    send_sample(11, -13, 1600, -40, 1'b0);
    send_sample(17, 19, 3200, -60, 1'b1);

    random_phase(170);

    // long receiver hold-off while batches keep coming
    hold_req = hold_req + 1;
    random_phase(60);

    set_bin(16'd0);
    random_phase(130);
    set_bin(16'd65535);
    random_phase(110);
    send_sample(1, 1, 32'sh80000000, 5, 1'b0);
    send_sample(2, 2, 32'sh7FFFFFFF, 6, 1'b1);

    set_bin(16'd1);
    gaps_on = 1'b0;
    random_phase(160);
    gaps_on = 1'b1;

    set_bin(16'd7);
    random_phase(50);

    set_bin(16'($urandom_range(2, 4000)));
    random_phase(140);

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
design/dbpf_pkg.sv
design/dbpf_in_if.sv
design/dbpf_out_if.sv
design/dbpf_sample_mem.sv
design/dbpf_bin_mem.sv
design/dbpf_divider.sv
design/depth_binned_peak_finder_unit.sv
sim/dbpf_checker.sv
sim/tb_top.sv
